// ===== rtl/gps_pkg.sv =====
// Package: phase codes, command tables and the result word type for the poll sequencer.
`default_nettype none
package gps_pkg;

    localparam int unsigned DeadZoneW     = 7;
    localparam logic [6:0]  DeadZoneReset = 7'd7;
    localparam logic [7:0]  IdAnalog      = 8'hF3;
    localparam logic [7:0]  RestValue     = 8'h7F;
    localparam logic [3:0]  ConnLen       = 4'd5;
    localparam logic [3:0]  FullLen       = 4'd9;
    localparam logic [3:0]  LastIdx       = 4'd8;

    typedef enum logic [2:0] {
        PH_CONN  = 3'd0,
        PH_MODE  = 3'd1,
        PH_SETUP = 3'd2,
        PH_EXIT  = 3'd3,
        PH_RUN   = 3'd4
    } t_phase;

    // Input word kinds
    localparam logic KindTick = 1'b0;
    localparam logic KindByte = 1'b1;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select_active;
        logic        frame_done;
        logic [15:0] buttons;
        logic        command_active;
        logic        data_stable;
        logic [7:0]  stick_rx;
        logic [7:0]  stick_ry;
        logic [7:0]  stick_lx;
        logic [7:0]  stick_ly;
        logic        analog_ready;
    } t_result;

    // Command byte of a frame at a byte position (positions past the end read the last one)
    function automatic logic [7:0] cmd_byte(input t_phase ph, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (ph)
            PH_MODE: begin
                unique case (idx)
                    4'd0:    b = 8'h01;
                    4'd1:    b = 8'h44;
                    4'd3:    b = 8'h01;
                    4'd4:    b = 8'h03;
                    default: b = 8'h00;
                endcase
            end
            PH_EXIT: begin
                unique case (idx)
                    4'd0:    b = 8'h01;
                    4'd1:    b = 8'h43;
                    4'd2:    b = 8'h00;
                    4'd3:    b = 8'h00;
                    default: b = 8'h5A;
                endcase
            end
            PH_SETUP, PH_RUN: begin
                unique case (idx)
                    4'd0:    b = 8'h01;
                    4'd1:    b = 8'h42;
                    default: b = 8'h00;
                endcase
            end
            default: begin
                unique case (idx)
                    4'd0:    b = 8'h01;
                    4'd1:    b = 8'h43;
                    4'd3:    b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

    // Stick byte lies within the rest band around the center value
    function automatic logic in_band(input logic [7:0] v, input logic [6:0] dz);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = RestValue - {1'b0, dz};
        hi = RestValue + {1'b0, dz};
        return (v >= lo) && (v <= hi);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gps_seq.sv =====
// Frame sequencer: phase, byte position and frame bytes, plus the result of one word.
`default_nettype none
module gps_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_kind,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic [gps_pkg::DeadZoneW-1:0] i_dead_zone,
    output gps_pkg::t_result                   o_result
);
    import gps_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_byte_idx, n_byte_idx;
    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_last_stick, n_last_stick;
    logic [7:0]  r_frame [0:8];

    t_phase      cur_ph;
    logic [3:0]  idx;
    logic [3:0]  idx_next;
    logic [3:0]  len;
    logic        wr_en;
    logic [7:0]  b3, b4, b5, b6, b7, b8;
    logic        all_rest;
    t_result     res;

    // Fold unknown phase codes onto the connect frame
    always_comb begin
        unique case (r_phase)
            PH_MODE, PH_SETUP, PH_EXIT, PH_RUN: cur_ph = r_phase;
            default:                            cur_ph = PH_CONN;
        endcase
    end

    assign idx      = (r_byte_idx < LastIdx) ? r_byte_idx : LastIdx;
    assign idx_next = idx + 4'd1;
    assign len      = (cur_ph == PH_CONN) ? ConnLen : FullLen;
    assign wr_en    = (i_kind == KindByte) && r_in_frame;

    // Frame bytes at poll end; the last one arrives with this word
    assign b3 = r_frame[3];
    assign b4 = r_frame[4];
    assign b5 = r_frame[5];
    assign b6 = r_frame[6];
    assign b7 = r_frame[7];
    assign b8 = i_rx_byte;
    assign all_rest = (b3 == 8'hFF) && (b4 == 8'hFF)
                   && in_band(b5, i_dead_zone) && in_band(b6, i_dead_zone)
                   && in_band(b7, i_dead_zone) && in_band(b8, i_dead_zone);

    // Step the sequencer for one word
    always_comb begin
        n_phase      = r_phase;
        n_byte_idx   = r_byte_idx;
        n_in_frame   = r_in_frame;
        n_last_stick = r_last_stick;
        res          = '0;
        if (i_kind == KindTick) begin
            if (!r_in_frame) begin
                n_in_frame   = 1'b1;
                n_byte_idx   = 4'd0;
                res.tx_valid = 1'b1;
                res.tx_byte  = cmd_byte(cur_ph, 4'd0);
            end
            res.select_active = 1'b1;
        end else if (r_in_frame) begin
            n_byte_idx = idx_next;
            if (idx_next < len) begin
                res.tx_valid      = 1'b1;
                res.tx_byte       = cmd_byte(cur_ph, idx_next);
                res.select_active = 1'b1;
            end else begin
                n_in_frame     = 1'b0;
                n_byte_idx     = 4'd0;
                res.frame_done = 1'b1;
                unique case (cur_ph)
                    PH_RUN: begin
                        res.buttons        = ~{b4, b3};
                        res.command_active = !all_rest;
                        res.data_stable    = (b5 == r_last_stick);
                        n_last_stick       = b5;
                        res.stick_rx       = b5;
                        res.stick_ry       = b6;
                        res.stick_lx       = b7;
                        res.stick_ly       = b8;
                    end
                    PH_EXIT:  n_phase = (r_frame[1] == IdAnalog) ? PH_RUN : PH_CONN;
                    PH_CONN:  n_phase = PH_MODE;
                    PH_MODE:  n_phase = PH_SETUP;
                    default:  n_phase = PH_EXIT;
                endcase
            end
        end
        res.analog_ready = (n_phase == PH_RUN);
    end

    assign o_result = res;

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CONN;
            r_byte_idx   <= 4'd0;
            r_in_frame   <= 1'b0;
            r_last_stick <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_byte_idx   <= n_byte_idx;
            r_in_frame   <= n_in_frame;
            r_last_stick <= n_last_stick;
        end
    end

    // Store received frame bytes
    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_frame[idx] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gamepad_poll_sequencer.sv =====
// Top level: input and result registers, dead zone register and the frame sequencer.
//
// Usage: each input word is either a scan tick (kind 0) that opens a frame or a
// byte received from the pad (kind 1). Every accepted word yields exactly one
// result word carrying the next command byte to shift out, the select state,
// the frame end flag and, at the end of a poll frame, buttons and sticks.
// Both data channels use valid/stall; a word moves when valid is high and
// stall is low. The dead zone register is written through its own valid/ready
// port, which is always ready; write it only while the block is idle.
// A word accepted into the input register runs through the sequencer, and its
// result is held in the result register until the receiver takes it.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single input register feeding the sequencer.
// When the receiver stalls, the result holds and the input register fills;
// stall then reaches the sender once both stages are occupied.
// Reset (synchronous, active low) empties both stages, returns to the connect
// frame and loads the dead zone with 7.
`default_nettype none
module gamepad_poll_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gps_pkg::DeadZoneW-1:0] i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_tx_valid,
    output logic [7:0]                         o_tx_byte,
    output logic                               o_select_active,
    output logic                               o_frame_done,
    output logic [15:0]                        o_buttons,
    output logic                               o_command_active,
    output logic                               o_data_stable,
    output logic [7:0]                         o_stick_rx,
    output logic [7:0]                         o_stick_ry,
    output logic [7:0]                         o_stick_lx,
    output logic [7:0]                         o_stick_ly,
    output logic                               o_analog_ready
);
    import gps_pkg::*;

    logic                 r_in_valid;
    logic                 r_kind;
    logic [7:0]           r_rx_byte;
    logic                 r_out_valid;
    t_result              r_out;
    logic [DeadZoneW-1:0] r_dead_zone;
    logic                 step;
    t_result              seq_res;

    // Advance when the result register is free or being drained
    assign step        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !step;
    assign o_cfg_ready = 1'b1;

    // Capture input words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
    end

    // Hold the dead zone register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DeadZoneReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dead_zone <= i_cfg_data;
        end
    end

    gps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_kind      (r_kind),
        .i_rx_byte   (r_rx_byte),
        .i_dead_zone (r_dead_zone),
        .o_result    (seq_res)
    );

    // Register results; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_valid       = r_out.tx_valid;
    assign o_tx_byte        = r_out.tx_byte;
    assign o_select_active  = r_out.select_active;
    assign o_frame_done     = r_out.frame_done;
    assign o_buttons        = r_out.buttons;
    assign o_command_active = r_out.command_active;
    assign o_data_stable    = r_out.data_stable;
    assign o_stick_rx       = r_out.stick_rx;
    assign o_stick_ry       = r_out.stick_ry;
    assign o_stick_lx       = r_out.stick_lx;
    assign o_stick_ly       = r_out.stick_ly;
    assign o_analog_ready   = r_out.analog_ready;

endmodule
`default_nettype wire
